// ----- rtl/core/mi3_pkg.sv -----
// package for the 3x3 matrix inverse core: float types, latencies,
// minor operand tables, leading-zero count and the shared round/pack function
// no dependencies
package mi3_pkg;

   localparam int unsigned FP_W       = 32;
   localparam int unsigned N_ELEM     = 9;
   localparam int unsigned MUL_LAT    = 3;
   localparam int unsigned ADD_LAT    = 4;
   localparam int unsigned DIV_STEP   = 3;
   localparam int unsigned QUO_W      = 27;
   localparam int unsigned DIV_STAGES = QUO_W / DIV_STEP;
   localparam int unsigned DIV_LAT    = DIV_STAGES + 2;
   localparam int unsigned COF_LAT    = MUL_LAT + ADD_LAT;
   localparam int unsigned DET_LAT    = COF_LAT + MUL_LAT + 2 * ADD_LAT;
   localparam int unsigned PIPE_LAT   = DET_LAT + DIV_LAT;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

   typedef logic [FP_W-1:0]   fp_type;
   typedef logic signed [9:0] exp_type;
   typedef logic [26:0]       mant_type;
   typedef logic [3:0]        elem_idx_type;

   // minor |p q; r s| = p*s - q*r, element index is row*3+col
   localparam elem_idx_type MINOR_P [N_ELEM] = '{4'd4, 4'd3, 4'd3, 4'd1, 4'd0, 4'd0, 4'd1, 4'd0, 4'd0};
   localparam elem_idx_type MINOR_Q [N_ELEM] = '{4'd5, 4'd5, 4'd4, 4'd2, 4'd2, 4'd1, 4'd2, 4'd2, 4'd1};
   localparam elem_idx_type MINOR_R [N_ELEM] = '{4'd7, 4'd6, 4'd6, 4'd7, 4'd6, 4'd6, 4'd4, 4'd3, 4'd3};
   localparam elem_idx_type MINOR_S [N_ELEM] = '{4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd7, 4'd5, 4'd5, 4'd4};
   localparam logic [N_ELEM-1:0] COF_NEG = 9'b010101010;

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            n = 6'(47 - i);
         end
      end
      return n;
   endfunction

   // m has its leading one at bit 26 (or is zero), e is the biased exponent
   function automatic fp_type fp_pack(input logic sgn, input logic nan, input logic inf,
                                      input exp_type e, input mant_type m, input logic st);
      mant_type    mm;
      logic        stk;
      logic [7:0]  fld;
      logic        inc;
      logic [30:0] mag;
      exp_type     rsh;
      fp_type      res;
      mm  = m;
      stk = st;
      fld = 8'd0;
      rsh = '0;
      if (e >= 10'sd1) begin
         fld = e[7:0];
      end else begin
         rsh = 10'sd1 - e;
         if (rsh > 10'sd26) begin
            mm  = '0;
            stk = (|m) | st;
         end else begin
            mm  = m >> rsh[4:0];
            stk = st | (|(m & ((27'd1 << rsh[4:0]) - 27'd1)));
         end
      end
      inc = mm[2] & (mm[3] | mm[1] | mm[0] | stk);
      mag = {fld, mm[25:3]} + 31'(inc);
      if (nan) begin
         res = CANON_NAN;
      end else if (inf) begin
         res = {sgn, 8'hFF, 23'd0};
      end else if (m == '0) begin
         res = {sgn, 31'd0};
      end else if (e > 10'sd254) begin
         res = {sgn, 8'hFF, 23'd0};
      end else begin
         res = {sgn, mag};
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/matrix_inverse_3x3_core.sv -----
// 3x3 single-precision matrix inverse by the adjugate, top level
// depends on mi3_pkg, mi3_fmul, mi3_fadd, mi3_fdiv
// Takes one matrix per clock unless the pipe is stalled. The path is 18
// multipliers, 9 subtractors for the cofactors, 3 multipliers and two
// adders for the determinant, then 9 dividers that produce 3 quotient bits
// per stage over 9 stages; all units share one advance signal, so a
// rsp_tready held low stops the whole pipe once its last stage is full, while a new
// request is taken whenever the last stage is empty. A zero
// determinant raises rsp_tuser and forces every result element to +0; any
// NaN result comes out as 0x7FC00000.
module matrix_inverse_3x3_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [287:0] req_tdata,  // a00, a01, a02, a10, a11, a12, a20, a21, a22
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,  // inv00, inv01, inv02, inv10, ..., inv22
   output logic         rsp_tuser   // singular
);
   import mi3_pkg::*;

   fp_type a      [N_ELEM];
   fp_type ps     [N_ELEM];
   fp_type qr     [N_ELEM];
   fp_type mnr    [N_ELEM];
   fp_type cof    [N_ELEM];
   fp_type quo    [N_ELEM];
   fp_type dprod  [3];
   fp_type dsum;
   fp_type det;

   fp_type acol_ff [COF_LAT][3];
   fp_type p2_ff   [ADD_LAT];
   fp_type cofd_ff [DET_LAT-COF_LAT][N_ELEM];
   fp_type detd_ff [DIV_LAT];

   logic [PIPE_LAT-1:0] vld_ff;
   logic                en;
   logic                take;
   logic                singular;
   logic                rsp_valid_ff;
   logic [287:0]        rsp_data_ff, rsp_data_in;
   logic                rsp_sing_ff;

   assign take       = !rsp_valid_ff || rsp_tready;
   assign en         = take || !vld_ff[PIPE_LAT-1];
   assign req_tready = en;

   for (genvar k = 0; k < N_ELEM; k++) begin : g_cof
      assign a[k] = req_tdata[FP_W*k +: FP_W];

      mi3_fmul u_ps (.clock(clock), .en(en), .op_a(a[MINOR_P[k]]), .op_b(a[MINOR_S[k]]),
                     .res(ps[k]));
      mi3_fmul u_qr (.clock(clock), .en(en), .op_a(a[MINOR_Q[k]]), .op_b(a[MINOR_R[k]]),
                     .res(qr[k]));
      mi3_fadd u_sub (.clock(clock), .en(en), .op_a(ps[k]), .op_b({~qr[k][31], qr[k][30:0]}),
                      .res(mnr[k]));

      assign cof[k] = COF_NEG[k] ? {~mnr[k][31], mnr[k][30:0]} : mnr[k];
   end

   mi3_fmul u_d0 (.clock(clock), .en(en), .op_a(acol_ff[COF_LAT-1][0]), .op_b(cof[0]),
                  .res(dprod[0]));
   mi3_fmul u_d1 (.clock(clock), .en(en), .op_a(acol_ff[COF_LAT-1][1]), .op_b(cof[3]),
                  .res(dprod[1]));
   mi3_fmul u_d2 (.clock(clock), .en(en), .op_a(acol_ff[COF_LAT-1][2]), .op_b(cof[6]),
                  .res(dprod[2]));
   mi3_fadd u_s0 (.clock(clock), .en(en), .op_a(dprod[0]), .op_b(dprod[1]), .res(dsum));
   mi3_fadd u_s1 (.clock(clock), .en(en), .op_a(dsum), .op_b(p2_ff[ADD_LAT-1]), .res(det));

   for (genvar k = 0; k < N_ELEM; k++) begin : g_div
      mi3_fdiv u_div (.clock(clock), .en(en),
                      .op_a(cofd_ff[DET_LAT-COF_LAT-1][(k % 3) * 3 + (k / 3)]),
                      .op_b(det), .res(quo[k]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acol_ff[0][0] <= a[0];
         acol_ff[0][1] <= a[3];
         acol_ff[0][2] <= a[6];
         for (int i = 1; i < COF_LAT; i++) begin
            acol_ff[i] <= acol_ff[i-1];
         end
         p2_ff[0] <= dprod[2];
         for (int i = 1; i < ADD_LAT; i++) begin
            p2_ff[i] <= p2_ff[i-1];
         end
         cofd_ff[0] <= cof;
         for (int i = 1; i < DET_LAT - COF_LAT; i++) begin
            cofd_ff[i] <= cofd_ff[i-1];
         end
         detd_ff[0] <= det;
         for (int i = 1; i < DIV_LAT; i++) begin
            detd_ff[i] <= detd_ff[i-1];
         end
      end
   end

   assign singular = (detd_ff[DIV_LAT-1][30:0] == 31'd0);

   always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
         rsp_data_in[FP_W*k +: FP_W] = singular ? '0 : quo[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[PIPE_LAT-2:0], req_tvalid};
         end
         if (take) begin
            rsp_valid_ff <= vld_ff[PIPE_LAT-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && vld_ff[PIPE_LAT-1]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_sing_ff <= singular;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sing_ff;

endmodule

// ----- rtl/core/mi3_fmul.sv -----
// pipelined single-precision multiplier, round to nearest even, three stages
// depends on mi3_pkg
module mi3_fmul (
   input  logic           clock,
   input  logic           en,
   input  mi3_pkg::fp_type op_a,
   input  mi3_pkg::fp_type op_b,
   output mi3_pkg::fp_type res
);
   import mi3_pkg::*;

   logic [7:0]  ea, eb, ea1, eb1;
   logic [23:0] ma, mb;
   logic        an, bn, ai, bi, az, bz;
   logic        nan_in, inf_in, sgn_in;
   logic [47:0] prod_in, prod_ff;
   exp_type     e0_in, e0_ff;
   logic        nan1_ff, inf1_ff, sgn1_ff;

   logic [5:0]  lz;
   logic [47:0] norm;
   mant_type    m_in, m_ff;
   logic        st_in, st_ff;
   exp_type     e_in, e_ff;
   logic        nan2_ff, inf2_ff, sgn2_ff;
   fp_type      res_in, res_ff;

   always_comb begin
      ea      = op_a[30:23];
      eb      = op_b[30:23];
      ea1     = (ea == 8'd0) ? 8'd1 : ea;
      eb1     = (eb == 8'd0) ? 8'd1 : eb;
      ma      = {|ea, op_a[22:0]};
      mb      = {|eb, op_b[22:0]};
      an      = (ea == 8'hFF) && (op_a[22:0] != 23'd0);
      bn      = (eb == 8'hFF) && (op_b[22:0] != 23'd0);
      ai      = (ea == 8'hFF) && (op_a[22:0] == 23'd0);
      bi      = (eb == 8'hFF) && (op_b[22:0] == 23'd0);
      az      = (op_a[30:0] == 31'd0);
      bz      = (op_b[30:0] == 31'd0);
      nan_in  = an | bn | (ai & bz) | (bi & az);
      inf_in  = ~nan_in & (ai | bi);
      sgn_in  = op_a[31] ^ op_b[31];
      prod_in = ma * mb;
      e0_in   = $signed({2'b00, ea1}) + $signed({2'b00, eb1}) - 10'sd126;
   end

   always_comb begin
      lz    = lzc48(prod_ff);
      norm  = prod_ff << lz;
      m_in  = norm[47:21];
      st_in = |norm[20:0];
      e_in  = e0_ff - $signed({4'b0000, lz});
   end

   assign res_in = fp_pack(sgn2_ff, nan2_ff, inf2_ff, e_ff, m_ff, st_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         e0_ff   <= e0_in;
         nan1_ff <= nan_in;
         inf1_ff <= inf_in;
         sgn1_ff <= sgn_in;
         m_ff    <= m_in;
         st_ff   <= st_in;
         e_ff    <= e_in;
         nan2_ff <= nan1_ff;
         inf2_ff <= inf1_ff;
         sgn2_ff <= sgn1_ff;
         res_ff  <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- rtl/core/mi3_fadd.sv -----
// pipelined single-precision adder, round to nearest even, four stages
// depends on mi3_pkg
module mi3_fadd (
   input  logic           clock,
   input  logic           en,
   input  mi3_pkg::fp_type op_a,
   input  mi3_pkg::fp_type op_b,
   output mi3_pkg::fp_type res
);
   import mi3_pkg::*;

   fp_type      x, y;
   logic [7:0]  ex, ey, ex1, ey1;
   logic        an, bn, ai, bi;
   logic        nan_in, inf_in, sgn_in, zs_in, sub_in;
   logic [23:0] mx_in, my_in, mx_ff, my_ff;
   logic [7:0]  d_in, d_ff, ex_ff;
   logic        nan1_ff, inf1_ff, sgn1_ff, zs1_ff, sub_ff;

   logic [26:0] ext, al;
   logic        stk;
   logic [27:0] sum_in, sum_ff;
   logic [7:0]  ex2_ff;
   logic        nan2_ff, inf2_ff, sgn2_ff, zs2_ff;

   logic [5:0]  lz;
   mant_type    m_in, m_ff;
   logic        st_in, st_ff;
   exp_type     e_in, e_ff;
   logic        sgn3_in;
   logic        nan3_ff, inf3_ff, sgn3_ff;
   fp_type      res_in, res_ff;

   always_comb begin
      if (op_a[30:0] >= op_b[30:0]) begin
         x = op_a;
         y = op_b;
      end else begin
         x = op_b;
         y = op_a;
      end
      ex     = x[30:23];
      ey     = y[30:23];
      ex1    = (ex == 8'd0) ? 8'd1 : ex;
      ey1    = (ey == 8'd0) ? 8'd1 : ey;
      mx_in  = {|ex, x[22:0]};
      my_in  = {|ey, y[22:0]};
      d_in   = ex1 - ey1;
      an     = (op_a[30:23] == 8'hFF) && (op_a[22:0] != 23'd0);
      bn     = (op_b[30:23] == 8'hFF) && (op_b[22:0] != 23'd0);
      ai     = (op_a[30:23] == 8'hFF) && (op_a[22:0] == 23'd0);
      bi     = (op_b[30:23] == 8'hFF) && (op_b[22:0] == 23'd0);
      nan_in = an | bn | (ai & bi & (op_a[31] ^ op_b[31]));
      inf_in = ~nan_in & (ai | bi);
      sgn_in = inf_in ? (ai ? op_a[31] : op_b[31]) : x[31];
      zs_in  = x[31] & y[31];
      sub_in = x[31] ^ y[31];
   end

   always_comb begin
      ext = {my_ff, 3'b000};
      if (d_ff >= 8'd27) begin
         al  = '0;
         stk = |my_ff;
      end else begin
         al  = ext >> d_ff[4:0];
         stk = |(ext & ((27'd1 << d_ff[4:0]) - 27'd1));
      end
      al[0] = al[0] | stk;
      if (sub_ff) begin
         sum_in = {1'b0, mx_ff, 3'b000} - {1'b0, al};
      end else begin
         sum_in = {1'b0, mx_ff, 3'b000} + {1'b0, al};
      end
   end

   always_comb begin
      lz = 6'd0;
      if (sum_ff[27]) begin
         m_in  = sum_ff[27:1];
         st_in = sum_ff[0];
         e_in  = $signed({2'b00, ex2_ff}) + 10'sd1;
      end else begin
         lz    = lzc48({sum_ff[26:0], 21'h1F_FFFF});
         m_in  = sum_ff[26:0] << lz;
         st_in = 1'b0;
         e_in  = $signed({2'b00, ex2_ff}) - $signed({4'b0000, lz});
      end
      sgn3_in = (sum_ff == 28'd0 && !inf2_ff) ? zs2_ff : sgn2_ff;
   end

   assign res_in = fp_pack(sgn3_ff, nan3_ff, inf3_ff, e_ff, m_ff, st_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff   <= mx_in;
         my_ff   <= my_in;
         d_ff    <= d_in;
         ex_ff   <= ex1;
         nan1_ff <= nan_in;
         inf1_ff <= inf_in;
         sgn1_ff <= sgn_in;
         zs1_ff  <= zs_in;
         sub_ff  <= sub_in;
         sum_ff  <= sum_in;
         ex2_ff  <= ex_ff;
         nan2_ff <= nan1_ff;
         inf2_ff <= inf1_ff;
         sgn2_ff <= sgn1_ff;
         zs2_ff  <= zs1_ff;
         m_ff    <= m_in;
         st_ff   <= st_in;
         e_ff    <= e_in;
         nan3_ff <= nan2_ff;
         inf3_ff <= inf2_ff;
         sgn3_ff <= sgn3_in;
         res_ff  <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- rtl/core/mi3_fdiv.sv -----
// pipelined single-precision divider, restoring, DIV_STEP quotient bits per stage,
// round to nearest even; depends on mi3_pkg
module mi3_fdiv (
   input  logic           clock,
   input  logic           en,
   input  mi3_pkg::fp_type op_a,
   input  mi3_pkg::fp_type op_b,
   output mi3_pkg::fp_type res
);
   import mi3_pkg::*;

   typedef struct packed {
      logic    sgn;
      logic    nan;
      logic    inf;
      logic    zero;
      exp_type e;
   } div_tag_type;

   logic [7:0]  ea, eb, ea1, eb1;
   logic [23:0] ma, mb;
   logic [5:0]  lza, lzb;
   logic        an, bn, ai, bi, az, bz;
   div_tag_type tag_in;
   logic [23:0] man_in, mbn_in;

   logic [24:0]     rem_ff [DIV_STAGES+1];
   logic [QUO_W-1:0] quo_ff [DIV_STAGES+1];
   logic [23:0]     div_ff [DIV_STAGES+1];
   div_tag_type     tag_ff [DIV_STAGES+1];

   mant_type m_fin;
   exp_type  e_fin;
   fp_type   res_in, res_ff;

   always_comb begin
      ea     = op_a[30:23];
      eb     = op_b[30:23];
      ea1    = (ea == 8'd0) ? 8'd1 : ea;
      eb1    = (eb == 8'd0) ? 8'd1 : eb;
      ma     = {|ea, op_a[22:0]};
      mb     = {|eb, op_b[22:0]};
      lza    = lzc48({ma, 24'hFF_FFFF});
      lzb    = lzc48({mb, 24'hFF_FFFF});
      man_in = ma << lza;
      mbn_in = mb << lzb;
      an     = (ea == 8'hFF) && (op_a[22:0] != 23'd0);
      bn     = (eb == 8'hFF) && (op_b[22:0] != 23'd0);
      ai     = (ea == 8'hFF) && (op_a[22:0] == 23'd0);
      bi     = (eb == 8'hFF) && (op_b[22:0] == 23'd0);
      az     = (op_a[30:0] == 31'd0);
      bz     = (op_b[30:0] == 31'd0);
      tag_in.sgn  = op_a[31] ^ op_b[31];
      tag_in.nan  = an | bn | (az & bz) | (ai & bi);
      tag_in.inf  = ~tag_in.nan & (ai | bz);
      tag_in.zero = ~tag_in.nan & ~tag_in.inf & (az | bi);
      tag_in.e    = $signed({2'b00, ea1}) - $signed({4'b0000, lza})
                  - $signed({2'b00, eb1}) + $signed({4'b0000, lzb}) + 10'sd127;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {1'b0, man_in};
         quo_ff[0] <= '0;
         div_ff[0] <= mbn_in;
         tag_ff[0] <= tag_in;
      end
   end

   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
      logic [24:0]      rem_in;
      logic [QUO_W-1:0] quo_in;

      always_comb begin
         logic ge;
         rem_in = rem_ff[s-1];
         quo_in = quo_ff[s-1];
         for (int k = 0; k < DIV_STEP; k++) begin
            ge = rem_in >= {1'b0, div_ff[s-1]};
            if (ge) begin
               rem_in = rem_in - {1'b0, div_ff[s-1]};
            end
            rem_in = rem_in << 1;
            quo_in = {quo_in[QUO_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            quo_ff[s] <= quo_in;
            div_ff[s] <= div_ff[s-1];
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   always_comb begin
      if (quo_ff[DIV_STAGES][QUO_W-1]) begin
         m_fin = quo_ff[DIV_STAGES];
         e_fin = tag_ff[DIV_STAGES].e;
      end else begin
         m_fin = {quo_ff[DIV_STAGES][QUO_W-2:0], 1'b0};
         e_fin = tag_ff[DIV_STAGES].e - 10'sd1;
      end
      if (tag_ff[DIV_STAGES].zero) begin
         m_fin = '0;
      end
      res_in = fp_pack(tag_ff[DIV_STAGES].sgn, tag_ff[DIV_STAGES].nan,
                       tag_ff[DIV_STAGES].inf, e_fin, m_fin, |rem_ff[DIV_STAGES]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- bench/tb_matrix_inverse_3x3_core.sv -----
// self-checking testbench for matrix_inverse_3x3_core: stream driver, result monitor
// and a bit-exact single-precision adjugate inverse predictor built from integer arithmetic
// depends on mi3_pkg and the core rtl
module tb_matrix_inverse_3x3_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mi3_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 3000000;
   localparam int unsigned N_RANDOM    = 1750;

   typedef struct {
      logic         nan;
      logic         inf;
      logic         s;
      logic [23:0]  m;
      int           e;
   } unpacked_type;

   typedef struct {
      fp_type el [N_ELEM];
      logic   drain;
   } matrix_type;

   typedef struct {
      fp_type el [N_ELEM];
      logic   singular;
   } inverse_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [287:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [287:0] rsp_tdata;
   logic         rsp_tuser;

   matrix_type  pending_matrices[$];
   inverse_type expected_inverses[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          req_gap;
   int          rsp_stall;
   logic        stimulus_done;

   matrix_inverse_3x3_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic unpacked_type fp_unpack(input fp_type x);
      unpacked_type u;
      u.s   = x[31];
      u.nan = (x[30:23] == 8'hFF) && (x[22:0] != 0);
      u.inf = (x[30:23] == 8'hFF) && (x[22:0] == 0);
      if (x[30:23] == 8'd0) begin
         u.m = {1'b0, x[22:0]};
         u.e = -149;
      end else begin
         u.m = {1'b1, x[22:0]};
         u.e = int'(x[30:23]) - 150;
      end
      return u;
   endfunction

   // value is m * 2^e, round to nearest even with gradual underflow
   function automatic fp_type round_to_single(input logic s, input logic [129:0] m, input int e);
      int           p;
      int           sh;
      int           eq;
      int           biased;
      logic [129:0] q;
      logic         g;
      logic         st;
      if (m == 0) return {s, 31'd0};
      p = 0;
      for (int i = 0; i < 130; i++) begin
         if (m[i]) p = i;
      end
      sh = p - 23;
      if (sh < -149 - e) sh = -149 - e;
      if (sh > 130) begin
         q = 0;
         g = 1'b0;
         st = 1'b1;
      end else if (sh > 0) begin
         q  = m >> sh;
         g  = m[sh-1];
         st = |(m & ((130'd1 << (sh - 1)) - 130'd1));
         if (g && (st || q[0])) q = q + 1;
      end else begin
         q = m << (-sh);
      end
      eq = e + sh;
      if (q[24]) begin
         q = q >> 1;
         eq = eq + 1;
      end
      if (!q[23]) return {s, 8'd0, q[22:0]};
      biased = eq + 150;
      if (biased >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(biased), q[22:0]};
   endfunction

   function automatic fp_type fp_mul(input fp_type x, input fp_type y);
      unpacked_type a;
      unpacked_type b;
      a = fp_unpack(x);
      b = fp_unpack(y);
      if (a.nan || b.nan) return CANON_NAN;
      if ((a.inf && !b.inf && b.m == 0) || (b.inf && !a.inf && a.m == 0)) return CANON_NAN;
      if (a.inf || b.inf) return {a.s ^ b.s, 8'hFF, 23'd0};
      return round_to_single(a.s ^ b.s, 130'(a.m) * 130'(b.m), a.e + b.e);
   endfunction

   function automatic fp_type fp_add(input fp_type x, input fp_type y);
      unpacked_type        a;
      unpacked_type        b;
      unpacked_type        t;
      int                  d;
      logic signed [131:0] va;
      logic signed [131:0] vb;
      logic signed [131:0] total;
      logic [129:0]        mag;
      a = fp_unpack(x);
      b = fp_unpack(y);
      if (a.nan || b.nan) return CANON_NAN;
      if (a.inf && b.inf && (a.s != b.s)) return CANON_NAN;
      if (a.inf) return x;
      if (b.inf) return y;
      if (b.e > a.e) begin
         t = a;
         a = b;
         b = t;
      end
      d = a.e - b.e;
      // far smaller operand only matters below the rounding bit
      if (d > 80) begin
         b.m = (b.m != 0) ? 24'd1 : 24'd0;
         d = 80;
      end
      va = 132'(a.m) << d;
      vb = 132'(b.m);
      if (a.s) va = -va;
      if (b.s) vb = -vb;
      total = va + vb;
      if (total == 0) return {a.s & b.s, 31'd0};
      mag = (total < 0) ? 130'(-total) : 130'(total);
      return round_to_single(total < 0, mag, a.e - d);
   endfunction

   function automatic fp_type fp_div(input fp_type x, input fp_type y);
      unpacked_type a;
      unpacked_type b;
      logic [129:0] num;
      logic [129:0] quo;
      logic [129:0] rem;
      logic         s;
      a = fp_unpack(x);
      b = fp_unpack(y);
      s = a.s ^ b.s;
      if (a.nan || b.nan || (a.inf && b.inf)) return CANON_NAN;
      if (!a.inf && !b.inf && a.m == 0 && b.m == 0) return CANON_NAN;
      if (a.inf) return {s, 8'hFF, 23'd0};
      if (b.inf || a.m == 0) return {s, 31'd0};
      if (b.m == 0) return {s, 8'hFF, 23'd0};
      num = 130'(a.m) << 60;
      quo = num / 130'(b.m);
      rem = num % 130'(b.m);
      return round_to_single(s, (quo << 1) | 130'(rem != 0), a.e - b.e - 61);
   endfunction

   function automatic fp_type fp_minor(input fp_type p, input fp_type q, input fp_type r,
                                       input fp_type s);
      return fp_add(fp_mul(p, s), fp_mul(q, r) ^ 32'h8000_0000);
   endfunction

   function automatic inverse_type adjugate_inverse(input matrix_type mx);
      fp_type      cof [N_ELEM];
      fp_type      a [N_ELEM];
      fp_type      det;
      fp_type      q;
      inverse_type res;
      a = mx.el;
      cof[0] = fp_minor(a[4], a[5], a[7], a[8]);
      cof[1] = fp_minor(a[3], a[5], a[6], a[8]) ^ 32'h8000_0000;
      cof[2] = fp_minor(a[3], a[4], a[6], a[7]);
      cof[3] = fp_minor(a[1], a[2], a[7], a[8]) ^ 32'h8000_0000;
      cof[4] = fp_minor(a[0], a[2], a[6], a[8]);
      cof[5] = fp_minor(a[0], a[1], a[6], a[7]) ^ 32'h8000_0000;
      cof[6] = fp_minor(a[1], a[2], a[4], a[5]);
      cof[7] = fp_minor(a[0], a[2], a[3], a[5]) ^ 32'h8000_0000;
      cof[8] = fp_minor(a[0], a[1], a[3], a[4]);
      det = fp_add(fp_add(fp_mul(a[0], cof[0]), fp_mul(a[3], cof[3])), fp_mul(a[6], cof[6]));
      res.singular = (det[30:0] == 31'd0);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            q = fp_div(cof[c*3+r], det);
            res.el[r*3+c] = res.singular ? 32'd0 : q;
         end
      end
      return res;
   endfunction

   function automatic fp_type random_element(input int kind);
      case (kind)
         0: return {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
         1: return {1'($urandom), 8'($urandom_range(127, 130)), 23'($urandom_range(0, 7)) << 20};
         2: return $urandom;
         default: begin
            case ($urandom_range(0, 10))
               0: return 32'h0000_0000;
               1: return 32'h8000_0000;
               2: return {1'($urandom), 8'hFF, 23'd0};
               3: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
               4: return {1'($urandom), 31'h7F7F_FFFF};
               5: return {1'($urandom), 31'd1};
               6: return {1'($urandom), 8'd0, 23'($urandom)};
               7: return {1'($urandom), 8'($urandom_range(200, 254)), 23'($urandom)};
               8: return {1'($urandom), 8'($urandom_range(1, 40)), 23'($urandom)};
               default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
            endcase
         end
      endcase
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type mx;
      int         sel;
      int         kind;
      sel = $urandom_range(0, 99);
      kind = (sel < 50) ? 0 : (sel < 60) ? 1 : (sel < 75) ? 2 : (sel < 85) ? 3 : 0;
      for (int i = 0; i < N_ELEM; i++) begin
         mx.el[i] = random_element(($urandom_range(0, 9) == 0 && kind == 0) ? 3 : kind);
      end
      // rank-deficient shapes: repeated row, repeated column, zero row
      if (sel >= 85) begin
         case ($urandom_range(0, 2))
            0: for (int c = 0; c < 3; c++) mx.el[6+c] = mx.el[c];
            1: for (int r = 0; r < 3; r++) mx.el[r*3+2] = mx.el[r*3];
            default: for (int c = 0; c < 3; c++) mx.el[3+c] = 32'd0;
         endcase
      end
      mx.drain = 1'b0;
      return mx;
   endfunction

   task automatic add_matrix(input fp_type e0, e1, e2, e3, e4, e5, e6, e7, e8);
      matrix_type mx;
      mx.el = '{e0, e1, e2, e3, e4, e5, e6, e7, e8};
      mx.drain = 1'b0;
      pending_matrices.push_back(mx);
   endtask

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(21, 120);
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      matrix_type mx;
      reset = 1'b1;
      stimulus_done = 1'b0;
      add_matrix(32'h3F80_0000, 0, 0, 0, 32'h3F80_0000, 0, 0, 0, 32'h3F80_0000);
      add_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_matrix(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000);
      add_matrix(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 32'h40A0_0000,
                 32'h40C0_0000, 32'h40E0_0000, 32'h4100_0000, 32'h4110_0000);
      add_matrix(32'h4000_0000, 32'h3F80_0000, 0, 32'h3F80_0000, 32'h4000_0000, 32'h3F80_0000,
                 0, 32'h3F80_0000, 32'h4000_0000);
      add_matrix(32'h7FC0_0000, 0, 0, 0, 32'h3F80_0000, 0, 0, 0, 32'h3F80_0000);
      add_matrix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_matrix(32'h7F80_0000, 0, 0, 0, 32'h3F80_0000, 0, 0, 0, 32'h3F80_0000);
      add_matrix(32'hFF80_0000, 32'h3F80_0000, 0, 0, 32'h3F80_0000, 0, 0, 0, 32'h7F80_0000);
      add_matrix(32'h7F7F_FFFF, 0, 0, 0, 32'h7F7F_FFFF, 0, 0, 0, 32'h7F7F_FFFF);
      add_matrix(32'h0000_0001, 0, 0, 0, 32'h0000_0001, 0, 0, 0, 32'h0000_0001);
      add_matrix(32'h0080_0000, 32'h807F_FFFF, 0, 0, 32'h0080_0000, 0, 0, 0, 32'h0080_0000);
      add_matrix(32'h1000_0000, 0, 0, 0, 32'h1000_0000, 0, 0, 0, 32'h1000_0000);
      add_matrix(32'h6000_0000, 0, 0, 0, 32'h6000_0000, 0, 0, 0, 32'h6000_0000);
      add_matrix(32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000,
                 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000);
      add_matrix(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
                 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
      add_matrix(32'h4B80_0001, 32'h4B80_0000, 0, 32'h4B80_0000, 32'h4B7F_FFFF, 0,
                 0, 0, 32'h3F80_0000);
      for (int n = 0; n < N_RANDOM; n++) begin
         mx = random_matrix();
         mx.drain = (n == 600 || n == 1200);
         pending_matrices.push_back(mx);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (pending_matrices.size() != 0 || req_tvalid || expected_inverses.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LAT + 20) @(posedge clock);
      stimulus_done = 1'b1;
      if (error_count == 0 && expected_inverses.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      matrix_type mx;
      logic       next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            mx = pending_matrices.pop_front();
            expected_inverses.push_back(adjugate_inverse(mx));
            req_gap = random_gap();
         end
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_matrices.size() != 0) begin
            mx = pending_matrices[0];
            if (!mx.drain || expected_inverses.size() == 0) begin
               next_valid = 1'b1;
               for (int i = 0; i < N_ELEM; i++) req_tdata[32*i +: 32] <= mx.el[i];
               if (mx.drain) pending_matrices[0].drain = 1'b0;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // result monitor
   always @(posedge clock) begin
      inverse_type exp_inv;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_inverses.size() == 0) begin
               $error("unexpected result: inverse with no request outstanding");
               error_count++;
            end else begin
               exp_inv = expected_inverses.pop_front();
               for (int i = 0; i < N_ELEM; i++) begin
                  if (rsp_tdata[32*i +: 32] !== exp_inv.el[i]) begin
                     $error("inv%0d%0d: expected %h, actual %h", i / 3, i % 3,
                            exp_inv.el[i], rsp_tdata[32*i +: 32]);
                     error_count++;
                  end
               end
               if (rsp_tuser !== exp_inv.singular) begin
                  $error("singular: expected %b, actual %b", exp_inv.singular, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_stall = ($urandom_range(0, 3) == 0) ? random_gap() : 0;
            rsp_tready <= (rsp_stall == 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT && !stimulus_done) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
